/* sv/blc_pkg.sv */
// Shared types and constants for the bounded integer list.
// Used by blc_cell and the top level bounded_integer_list; no dependencies.
package blc_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Field widths of the transfer payloads.
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Internal widths derived from the list depth.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Cells are grouped for the two-level first-match and read-out trees.
    localparam int GRP   = 8;
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam int SLOTS = NGRP * GRP;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_READ      = 3'd1,
        CMD_POP_HEAD  = 3'd2,
        CMD_POP_BACK  = 3'd3,
        CMD_REMOVE    = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          index;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      found;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
        logic [STAT_W-1:0]         status;
    } out_item_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic eval_en;
        logic scan_en;
        logic write_en;
        logic shift_all;
        logic shift_sel;
    } cell_ctrl_t;

endpackage

/* sv/bounded_integer_list.sv */
// Top level of the bounded integer list: cell row, grouping trees, sequencer, result register.
// Depends on blc_pkg and blc_cell.
//
// The list keeps up to DEPTH entries packed head first in a row of cells, one entry per
// cell. Every command passes four steps from transfer to result: the accept cycle, a
// compare cycle in which each cell checks its entry against the key and its position
// against the read index, a scan cycle that forms the first-match prefix inside groups
// of eight cells, and an apply cycle that combines the groups, shifts the later entries
// one cell toward the head on a removal and loads the result register. A new command is
// taken in the cycle after apply, so the block takes no new command while one is in work.
// The result register holds a finished result while the next command is worked on; the
// apply cycle waits only while an earlier result has not yet been taken.
module bounded_integer_list
    import blc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EVAL  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    logic [CMD_W-1:0] op_cmd_reg;
    data_t            op_value_reg;
    logic [IDX_W-1:0] op_index_reg;

    data_t            entry   [SLOTS];
    data_t            rd_part [SLOTS];
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] seen;

    data_t            grp_rd_c   [NGRP];
    data_t            grp_rd_reg [NGRP];
    logic [NGRP-1:0]  grp_match_c, grp_match_reg;
    logic [NGRP-1:0]  grp_prior;

    data_t            rd_all;
    logic             any_match;
    logic             accept;
    logic             apply_fire;
    cell_ctrl_t       ctrl;

    logic             write_c, shift_all_c, shift_sel_c, found_c;
    status_t          status_c;
    data_t            rd_out_c;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign apply_fire = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);

    // Cell row; slots past DEPTH pad the last group.
    for (genvar i = 0; i < SLOTS; i++) begin : g_slot
        if (i < DEPTH) begin : g_cell
            logic  seen_in;
            data_t next_entry;
            if (i % GRP == 0) begin : g_first
                assign seen_in = 1'b0;
            end else begin : g_rest
                assign seen_in = seen[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign next_entry = '0;
            end else begin : g_mid
                assign next_entry = entry[i+1];
            end
            blc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .cell_pos   (POS_W'(i)),
                .count      (count_reg),
                .key        (op_value_reg),
                .index      (op_index_reg),
                .next_entry (next_entry),
                .seen_in    (seen_in),
                .prior_in   (grp_prior[i / GRP]),
                .entry      (entry[i]),
                .match      (match[i]),
                .seen_out   (seen[i]),
                .rd_part    (rd_part[i])
            );
        end else begin : g_pad
            assign entry[i]   = '0;
            assign rd_part[i] = '0;
            assign match[i]   = 1'b0;
            assign seen[i]    = 1'b0;
        end
    end

    // First level: per-group read-out and match, registered in the scan cycle.
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            grp_rd_c[g]    = '0;
            grp_match_c[g] = 1'b0;
            for (int k = 0; k < GRP; k++) begin
                grp_rd_c[g]    = grp_rd_c[g] | rd_part[g*GRP + k];
                grp_match_c[g] = grp_match_c[g] | match[g*GRP + k];
            end
        end
        always_ff @(posedge aclk) begin
            if (state_reg == ST_SCAN) begin
                grp_rd_reg[g] <= grp_rd_c[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            grp_match_reg <= grp_match_c;
        end
    end

    // Second level: a group shifts whole once any earlier group holds the match.
    always_comb begin
        logic run;
        run    = 1'b0;
        rd_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            grp_prior[g] = run;
            run          = run | grp_match_reg[g];
            rd_all       = rd_all | grp_rd_reg[g];
        end
        any_match = run;
    end

    always_comb begin
        count_next  = count_reg;
        status_c    = STAT_OK;
        rd_out_c    = '0;
        found_c     = 1'b0;
        write_c     = 1'b0;
        shift_all_c = 1'b0;
        shift_sel_c = 1'b0;
        unique case (op_cmd_reg)
            CMD_APPEND: begin
                if (count_reg == CNT_W'(DEPTH)) begin
                    status_c = STAT_FULL;
                end else begin
                    write_c    = 1'b1;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            CMD_READ: begin
                if (CMP_W'(op_index_reg) < CMP_W'(count_reg)) begin
                    rd_out_c = rd_all;
                end else begin
                    status_c = STAT_RANGE;
                end
            end
            CMD_POP_HEAD: begin
                if (count_reg == '0) begin
                    status_c = STAT_EMPTY;
                end else begin
                    shift_all_c = 1'b1;
                    count_next  = CNT_W'(count_reg - 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (count_reg == '0) begin
                    status_c = STAT_EMPTY;
                end else begin
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (count_reg == '0) begin
                    status_c = STAT_EMPTY;
                end else if (any_match) begin
                    found_c     = 1'b1;
                    shift_sel_c = 1'b1;
                    count_next  = CNT_W'(count_reg - 1'b1);
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctrl.eval_en   = (state_reg == ST_EVAL);
        ctrl.scan_en   = (state_reg == ST_SCAN);
        ctrl.write_en  = apply_fire && write_c;
        ctrl.shift_all = apply_fire && shift_all_c;
        ctrl.shift_sel = apply_fire && shift_sel_c;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_SCAN;
            ST_SCAN:  state_next = ST_APPLY;
            ST_APPLY: if (apply_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (apply_fire) begin
            m_valid_next           = 1'b1;
            m_item_next.read_value = $signed(VALUE_W'(rd_out_c));
            m_item_next.found      = found_c;
            m_item_next.count      = COUNT_W'(count_next);
            m_item_next.empty_res  = (count_next == '0);
            m_item_next.status     = status_c;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (apply_fire) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (accept) begin
            op_cmd_reg   <= s_item.cmd;
            op_value_reg <= data_t'(s_item.value);
            op_index_reg <= s_item.index;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        apply_fire && (op_cmd_reg != CMD_CLEAR) |=>
            (count_reg == $past(count_reg)) ||
            (count_reg == CNT_W'($past(count_reg) + 1'b1)) ||
            (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.found |-> m_item_reg.status == STAT_OK)
        else $error("found reported with a failing status");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.empty_res == (m_item_reg.count == '0))
        else $error("empty flag disagrees with count");

endmodule

/* sv/blc_cell.sv */
// One entry cell of the list: holds an entry and hands it to its head-side neighbor.
// Depends on blc_pkg for widths and the cell control struct.
module blc_cell
    import blc_pkg::*;
(
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [POS_W-1:0] cell_pos,
    input  logic [CNT_W-1:0] count,
    input  data_t            key,
    input  logic [IDX_W-1:0] index,
    input  data_t            next_entry,
    input  logic             seen_in,
    input  logic             prior_in,
    output data_t            entry,
    output logic             match,
    output logic             seen_out,
    output data_t            rd_part
);

    data_t entry_reg, entry_next;
    logic  match_reg, match_next;
    logic  hit_reg, hit_next;
    logic  pre_reg, pre_next;
    logic  in_use;
    logic  at_tail;

    assign in_use  = CMP_W'(cell_pos) < CMP_W'(count);
    assign at_tail = CMP_W'(cell_pos) == CMP_W'(count);

    // Within a group, seen_out is high from the first matching cell onward.
    assign seen_out = seen_in | match_reg;

    always_comb begin
        match_next = match_reg;
        hit_next   = hit_reg;
        pre_next   = pre_reg;
        entry_next = entry_reg;
        if (ctrl.eval_en) begin
            match_next = in_use && (entry_reg == key);
            hit_next   = CMP_W'(cell_pos) == CMP_W'(index);
        end
        if (ctrl.scan_en) begin
            pre_next = seen_out;
        end
        if (ctrl.write_en && at_tail) begin
            entry_next = key;
        end else if (ctrl.shift_all || (ctrl.shift_sel && (pre_reg || prior_in))) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        match_reg <= match_next;
        hit_reg   <= hit_next;
        pre_reg   <= pre_next;
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign match   = match_reg;
    assign rd_part = hit_reg ? entry_reg : '0;

endmodule

/* tb/tb_bounded_integer_list.sv */
// Self-checking testbench for bounded_integer_list: a directed opening, then random
// command episodes with random idling on both channels. Depends on blc_pkg and the RTL.
`timescale 1ns / 100ps

// Tracks the list contents as commands are accepted and holds the results they must give.
class list_tracker;
    blc_pkg::data_t       cells [blc_pkg::DEPTH];
    int unsigned          held;
    blc_pkg::out_item_t   awaited [$];
    int unsigned          errors;

    function new();
        held   = 0;
        errors = 0;
    endfunction

    function automatic blc_pkg::data_t entry_at(int unsigned pos);
        return cells[pos];
    endfunction

    function automatic int unsigned pending();
        return awaited.size();
    endfunction

    local function automatic void drop_at(int unsigned pos);
        for (int unsigned i = pos; i + 1 < held; i++) begin
            cells[i] = cells[i + 1];
        end
        held--;
    endfunction

    // Applies one accepted command to the list and queues the result it produces.
    function automatic void note_command(blc_pkg::in_item_t cmd_in);
        blc_pkg::out_item_t res;
        blc_pkg::data_t     key;
        res = '0;
        key = blc_pkg::data_t'(cmd_in.value);
        res.status = blc_pkg::STAT_OK;
        case (cmd_in.cmd)
            blc_pkg::CMD_APPEND: begin
                if (held >= blc_pkg::DEPTH) begin
                    res.status = blc_pkg::STAT_FULL;
                end else begin
                    cells[held] = key;
                    held++;
                end
            end
            blc_pkg::CMD_READ: begin
                if (cmd_in.index < held) begin
                    res.read_value = cells[cmd_in.index];
                end else begin
                    res.status = blc_pkg::STAT_RANGE;
                end
            end
            blc_pkg::CMD_POP_HEAD: begin
                if (held == 0) res.status = blc_pkg::STAT_EMPTY;
                else drop_at(0);
            end
            blc_pkg::CMD_POP_BACK: begin
                if (held == 0) res.status = blc_pkg::STAT_EMPTY;
                else held--;
            end
            blc_pkg::CMD_REMOVE: begin
                if (held == 0) begin
                    res.status = blc_pkg::STAT_EMPTY;
                end else begin
                    for (int unsigned i = 0; i < held; i++) begin
                        if (cells[i] == key) begin
                            drop_at(i);
                            res.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            blc_pkg::CMD_CLEAR: held = 0;
            default: ;
        endcase
        res.count     = blc_pkg::COUNT_W'(held);
        res.empty_res = (held == 0);
        awaited.push_back(res);
    endfunction

    function automatic void check_result(blc_pkg::out_item_t got);
        blc_pkg::out_item_t want;
        if (awaited.size() == 0) begin
            $error("result transfer with no command outstanding: %h", got);
            errors++;
            return;
        end
        want = awaited[0];
        awaited.delete(0);
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            errors++;
        end
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
        end
        if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            errors++;
        end
        if (got.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
    endfunction
endclass

module tb_bounded_integer_list;
    import blc_pkg::*;

    // Codes the block does not decode; they must leave the list alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam int RANDOM_COMMANDS = 1925;
    localparam int HOLD_AT_RESULT  = 400;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_LIMIT     = 5000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    list_tracker tracker;
    bit          no_idle;
    int unsigned results_taken;

    bounded_integer_list u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offers one command after a random gap and returns at the falling edge after the transfer.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                input logic [IDX_W-1:0] index);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item.cmd   = cmd;
        s_item.value = value;
        s_item.index = index;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.note_command(s_item);
        @(negedge aclk);
    endtask

    // Small values and the extremes make duplicates and boundary entries common.
    function automatic logic [VALUE_W-1:0] draw_value();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: return VALUE_W'($urandom_range(0, 8) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic random_command(input int mode);
        int                  r;
        logic [CMD_W-1:0]    cmd;
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    index;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 65)      cmd = CMD_APPEND;
                else if (r < 80) cmd = CMD_READ;
                else if (r < 90) cmd = CMD_REMOVE;
                else if (r < 95) cmd = CMD_POP_HEAD;
                else if (r < 98) cmd = CMD_POP_BACK;
                else             cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            MODE_DRAIN: begin
                if (r < 25)      cmd = CMD_POP_HEAD;
                else if (r < 50) cmd = CMD_POP_BACK;
                else if (r < 72) cmd = CMD_REMOVE;
                else if (r < 87) cmd = CMD_READ;
                else if (r < 96) cmd = CMD_APPEND;
                else if (r < 98) cmd = CMD_CLEAR;
                else             cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            default: begin
                if (r < 30)      cmd = CMD_APPEND;
                else if (r < 50) cmd = CMD_READ;
                else if (r < 62) cmd = CMD_POP_HEAD;
                else if (r < 74) cmd = CMD_POP_BACK;
                else if (r < 92) cmd = CMD_REMOVE;
                else if (r < 94) cmd = CMD_CLEAR;
                else             cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
        endcase
        value = draw_value();
        // Removals mostly name a value that is actually in the list.
        if (cmd == CMD_REMOVE && tracker.held > 0 && $urandom_range(0, 9) < 6) begin
            value = VALUE_W'(tracker.entry_at($urandom_range(0, tracker.held - 1)));
        end
        if (tracker.held > 0 && $urandom_range(0, 9) < 7) begin
            index = IDX_W'($urandom_range(0, tracker.held - 1));
        end else begin
            index = IDX_W'($urandom_range(0, 63));
        end
        send_command(cmd, value, index);
    endtask

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial begin
        int stall;
        m_ready       = 1'b0;
        results_taken = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (results_taken == HOLD_AT_RESULT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_result(m_item);
            results_taken++;
            @(negedge aclk);
        end
    end

    initial begin
        int sent;
        int mode;
        int run_len;
        int waited;
        bit leftover;
        tracker  = new();
        no_idle  = 1'b0;
        leftover = 1'b0;
        s_valid  = 1'b0;
        s_item   = '0;
        aresetn  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed opening: empty-list cases, boundary values, match and miss.
        send_command(CMD_READ, 32'd0, 6'd0);
        send_command(CMD_POP_HEAD, 32'd0, 6'd0);
        send_command(CMD_POP_BACK, 32'd0, 6'd0);
        send_command(CMD_REMOVE, 32'd5, 6'd0);
        send_command(CMD_SPARE_A, 32'hffff_ffff, 6'h3f);
        send_command(CMD_SPARE_B, 32'hffff_ffff, 6'h3f);
        send_command(CMD_APPEND, 32'h7fff_ffff, 6'd0);
        send_command(CMD_APPEND, 32'h8000_0000, 6'd0);
        send_command(CMD_APPEND, 32'h0000_0000, 6'd0);
        send_command(CMD_APPEND, 32'hffff_ffff, 6'd0);
        send_command(CMD_APPEND, 32'h7fff_ffff, 6'd0);
        send_command(CMD_SPARE_A, 32'd0, 6'd0);
        send_command(CMD_READ, 32'd0, 6'd0);
        send_command(CMD_READ, 32'd0, 6'd4);
        send_command(CMD_READ, 32'd0, 6'd5);
        send_command(CMD_READ, 32'd0, 6'h3f);
        send_command(CMD_REMOVE, 32'h7fff_ffff, 6'd0);
        send_command(CMD_REMOVE, 32'd12345, 6'd0);
        send_command(CMD_POP_HEAD, 32'd0, 6'd0);
        send_command(CMD_POP_BACK, 32'd0, 6'd0);
        send_command(CMD_READ, 32'd0, 6'd0);
        send_command(CMD_CLEAR, 32'd0, 6'd0);
        send_command(CMD_REMOVE, 32'hffff_ffff, 6'd0);
        send_command(CMD_APPEND, 32'h5555_5555, 6'h2a);
        send_command(CMD_CLEAR, 32'd0, 6'd0);

        // Random episodes; fill episodes are long enough to run the list into full.
        sent = 0;
        while (sent < RANDOM_COMMANDS) begin
            r_pick_mode: begin
                int r;
                r = $urandom_range(0, 99);
                mode = (r < 40) ? MODE_FILL : (r < 65) ? MODE_DRAIN : MODE_MIX;
            end
            run_len = (mode == MODE_FILL) ? $urandom_range(150, 250) : $urandom_range(20, 120);
            no_idle = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < run_len && sent < RANDOM_COMMANDS; k++) begin
                random_command(mode);
                sent++;
            end
        end
        no_idle = 1'b0;
        s_valid = 1'b0;

        waited = 0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (tracker.pending() != 0) begin
            $error("%0d expected results never arrived", tracker.pending());
            leftover = 1'b1;
        end
        repeat (20) @(posedge aclk);

        if (tracker.errors == 0 && !leftover) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/blc_pkg.sv
sv/blc_cell.sv
sv/bounded_integer_list.sv
tb/tb_bounded_integer_list.sv
